// ===== src/sbq_pkg.sv =====
// sbq_pkg: shared widths, status and request codes for the semaphore blocked-queue table
// no dependencies
package sbq_pkg;

   localparam int KEY_W        = 32;
   localparam int PROC_W       = 5;
   localparam int STATUS_W     = 2;
   localparam int DEF_MAX_PROCS = 32;

   localparam logic KIND_BLOCK   = 1'b0;
   localparam logic KIND_UNBLOCK = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FREE   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

endpackage

// ===== src/sbq_ram.sv =====
// sbq_ram: single write port, single read port synchronous memory, registered read data
// no dependencies
module sbq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AddrW-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AddrW-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/sbq_ctrl.sv =====
// sbq_ctrl: request sequencer; scans the descriptor memory, updates queue links, forms results
// depends on sbq_pkg; drives the descriptor and link memories (sbq_ram)
module sbq_ctrl #(
   parameter int MAX_PROCS = sbq_pkg::DEF_MAX_PROCS,
   localparam int IdxW  = $clog2(MAX_PROCS),
   localparam int CntW  = $clog2(MAX_PROCS + 1),
   localparam int DescW = sbq_pkg::KEY_W + 2 * IdxW + CntW
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [sbq_pkg::KEY_W-1:0]     req_sem_key,
   input  logic [sbq_pkg::PROC_W-1:0]    req_proc_id,
   output logic                          rsp_strobe,
   output logic [sbq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [sbq_pkg::PROC_W-1:0]    rsp_removed_proc,
   output logic                          desc_we,
   output logic [IdxW-1:0]               desc_waddr,
   output logic [DescW-1:0]              desc_wdata,
   output logic                          desc_re,
   output logic [IdxW-1:0]               desc_raddr,
   input  logic [DescW-1:0]              desc_rdata,
   output logic                          link_we,
   output logic [IdxW-1:0]               link_waddr,
   output logic [IdxW-1:0]               link_wdata,
   output logic                          link_re,
   output logic [IdxW-1:0]               link_raddr,
   input  logic [IdxW-1:0]               link_rdata
);

   import sbq_pkg::*;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [IdxW-1:0]  head;
      logic [IdxW-1:0]  tail;
      logic [CntW-1:0]  count;
   } desc_word_type;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_ACT  = 2'd2;
   localparam logic [1:0] S_POP  = 2'd3;

   localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_PROCS - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(MAX_PROCS);
   localparam logic [CntW-1:0] OneCnt  = CntW'(1);

   // proc_id reduced modulo the pool size
   logic [IdxW-1:0] pid_tbl [2**PROC_W];
   for (genvar i = 0; i < 2**PROC_W; i++) begin : g_pid_mod
      localparam int Rem = i % MAX_PROCS;
      assign pid_tbl[i] = IdxW'(Rem);
   end

   logic [1:0]            state_ff, state_in;
   logic                  kind_ff, kind_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [IdxW-1:0]       pid_ff, pid_in;
   logic [IdxW-1:0]       idx_ff, idx_in;
   logic                  free_found_ff, free_found_in;
   logic [IdxW-1:0]       free_idx_ff, free_idx_in;
   logic                  hit_ff, hit_in;
   logic [IdxW-1:0]       hit_idx_ff, hit_idx_in;
   desc_word_type         rec_ff, rec_in;
   logic [MAX_PROCS-1:0]  active_ff, active_in;
   logic                  strobe_ff, strobe_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [PROC_W-1:0]     removed_ff, removed_in;

   desc_word_type rd_word;
   desc_word_type wr_word;
   logic          cur_active;
   logic          cur_match;
   logic [IdxW-1:0] next_idx;

   assign rd_word    = desc_rdata;
   assign cur_active = active_ff[idx_ff];
   assign cur_match  = cur_active && (rd_word.key == key_ff);
   assign next_idx   = (idx_ff == LastIdx) ? '0 : idx_ff + IdxW'(1);
   assign busy       = (state_ff != S_IDLE);

   assign desc_re    = (state_ff == S_IDLE) || (state_ff == S_SCAN);
   assign desc_raddr = (state_ff == S_IDLE) ? '0 : next_idx;
   assign desc_wdata = wr_word;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      pid_in        = pid_ff;
      idx_in        = idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      rec_in        = rec_ff;
      active_in     = active_ff;
      strobe_in     = 1'b0;
      status_in     = status_ff;
      removed_in    = removed_ff;
      desc_we       = 1'b0;
      desc_waddr    = hit_idx_ff;
      wr_word       = rec_ff;
      link_we       = 1'b0;
      link_waddr    = rec_ff.tail;
      link_wdata    = pid_ff;
      link_re       = 1'b0;
      link_raddr    = rec_ff.head;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in       = req_kind;
               key_in        = req_sem_key;
               pid_in        = pid_tbl[req_proc_id];
               idx_in        = '0;
               free_found_in = 1'b0;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            if (cur_match) begin
               hit_in     = 1'b1;
               hit_idx_in = idx_ff;
               rec_in     = rd_word;
               state_in   = S_ACT;
            end else begin
               if (!cur_active && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_ff;
               end
               if (idx_ff == LastIdx) begin
                  hit_in   = 1'b0;
                  state_in = S_ACT;
               end else begin
                  idx_in = next_idx;
               end
            end
         end
         S_ACT: begin
            status_in  = STATUS_DONE;
            removed_in = '0;
            strobe_in  = 1'b1;
            state_in   = S_IDLE;
            if (kind_ff == KIND_BLOCK) begin
               if (hit_ff) begin
                  if (rec_ff.count >= FullCnt) begin
                     status_in = STATUS_NO_FREE;
                  end else begin
                     desc_we       = 1'b1;
                     wr_word.head  = (rec_ff.count == '0) ? pid_ff : rec_ff.head;
                     wr_word.tail  = pid_ff;
                     wr_word.count = rec_ff.count + OneCnt;
                     link_we       = (rec_ff.count != '0);
                  end
               end else if (free_found_ff) begin
                  desc_we                = 1'b1;
                  desc_waddr             = free_idx_ff;
                  wr_word.key            = key_ff;
                  wr_word.head           = pid_ff;
                  wr_word.tail           = pid_ff;
                  wr_word.count          = OneCnt;
                  active_in[free_idx_ff] = 1'b1;
               end else begin
                  status_in = STATUS_NO_FREE;
               end
            end else begin
               if (!hit_ff) begin
                  status_in = STATUS_NOT_FOUND;
               end else begin
                  removed_in = PROC_W'(rec_ff.head);
                  if (rec_ff.count <= OneCnt) begin
                     active_in[hit_idx_ff] = 1'b0;
                  end else begin
                     link_re   = 1'b1;
                     strobe_in = 1'b0;
                     state_in  = S_POP;
                  end
               end
            end
         end
         S_POP: begin
            desc_we       = 1'b1;
            wr_word.head  = link_rdata;
            wr_word.count = rec_ff.count - OneCnt;
            strobe_in     = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         active_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      pid_ff        <= pid_in;
      idx_ff        <= idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      rec_ff        <= rec_in;
      status_ff     <= status_in;
      removed_ff    <= removed_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_removed_proc = removed_ff;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> (state_ff == S_IDLE))
      else $error("result strobe while a transfer is still in progress");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff)
      else $error("result strobe held for more than one cycle");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_SCAN))
      else $error("accepted transfer did not start a descriptor scan");

   a_active_stable: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && ($past(state_ff) != S_ACT)) |-> $stable(active_ff))
      else $error("descriptor active bits changed outside the update cycle");

endmodule

// ===== src/semaphore_blocked_queue_table_core.sv =====
// semaphore_blocked_queue_table_core: top level of the semaphore blocked-queue table
// depends on sbq_pkg, sbq_ctrl and sbq_ram (descriptor memory and link memory)
// sequence: a request scans the descriptor memory linearly, one entry per cycle, until its
// key matches or the last entry is passed, so a miss scans every entry; the result is
// registered in S_ACT, or in S_POP for an unblock that leaves the queue non-empty
// throughput: one request at a time, busy falls in the cycle that carries the result strobe
// reset: control state cleared and all descriptors free at once, no clearing pass; results
// appear for exactly one cycle and the receiver cannot stall
module semaphore_blocked_queue_table_core #(
   parameter int MAX_PROCS = sbq_pkg::DEF_MAX_PROCS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [sbq_pkg::KEY_W-1:0]     req_sem_key,
   input  logic [sbq_pkg::PROC_W-1:0]    req_proc_id,
   output logic                          rsp_strobe,
   output logic [sbq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [sbq_pkg::PROC_W-1:0]    rsp_removed_proc
);

   import sbq_pkg::*;

   localparam int IdxW  = $clog2(MAX_PROCS);
   localparam int CntW  = $clog2(MAX_PROCS + 1);
   localparam int DescW = KEY_W + 2 * IdxW + CntW;

   logic             desc_we;
   logic [IdxW-1:0]  desc_waddr;
   logic [DescW-1:0] desc_wdata;
   logic             desc_re;
   logic [IdxW-1:0]  desc_raddr;
   logic [DescW-1:0] desc_rdata;
   logic             link_we;
   logic [IdxW-1:0]  link_waddr;
   logic [IdxW-1:0]  link_wdata;
   logic             link_re;
   logic [IdxW-1:0]  link_raddr;
   logic [IdxW-1:0]  link_rdata;

   sbq_ctrl #(
      .MAX_PROCS (MAX_PROCS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_sem_key      (req_sem_key),
      .req_proc_id      (req_proc_id),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_removed_proc (rsp_removed_proc),
      .desc_we          (desc_we),
      .desc_waddr       (desc_waddr),
      .desc_wdata       (desc_wdata),
      .desc_re          (desc_re),
      .desc_raddr       (desc_raddr),
      .desc_rdata       (desc_rdata),
      .link_we          (link_we),
      .link_waddr       (link_waddr),
      .link_wdata       (link_wdata),
      .link_re          (link_re),
      .link_raddr       (link_raddr),
      .link_rdata       (link_rdata)
   );

   sbq_ram #(
      .WIDTH (DescW),
      .DEPTH (MAX_PROCS)
   ) u_desc_ram (
      .clock (clock),
      .we    (desc_we),
      .waddr (desc_waddr),
      .wdata (desc_wdata),
      .re    (desc_re),
      .raddr (desc_raddr),
      .rdata (desc_rdata)
   );

   sbq_ram #(
      .WIDTH (IdxW),
      .DEPTH (MAX_PROCS)
   ) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .re    (link_re),
      .raddr (link_raddr),
      .rdata (link_rdata)
   );

endmodule
